// ===== hdl/lsefg_pkg.sv =====
// Shared types and constants of the LED strip effect frame generator.
// Used by lsefg_ctrl, lsefg_datapath and led_strip_effect_frame_gen; depends on nothing.
`default_nettype none

package lsefg_pkg;

   localparam int STRIP_LEDS_DEF     = 32;
   localparam int FRAME_INTERVAL_DEF = 50;

   localparam int TIME_W     = 32;
   localparam int LED_W      = 5;
   localparam int CHAN_W     = 8;
   localparam int CFG_CNT_W  = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;
   localparam int HUE_W      = 9;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_OUTPUT_ENABLE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ACTIVE_COUNT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BRIGHTNESS    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FIXED_RED     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FIXED_GREEN   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_FIXED_BLUE    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_EFFECT_MODE   = 3'd6;

   localparam logic [CFG_CNT_W-1:0] ACTIVE_COUNT_RST = 6'd8;
   localparam logic [CHAN_W-1:0]    CHAN_MAX         = 8'd255;

   localparam logic [HUE_W-1:0] HUE_FULL   = 9'd360;
   localparam logic [HUE_W-1:0] HUE_SECTOR = 9'd60;
   localparam logic [HUE_W-1:0] HUE_STEP   = 9'd5;

   typedef struct packed {
      logic frame_start;
      logic div_init;
      logic div_step;
      logic hue_load;
      logic color_load;
      logic scale_load;
      logic norm_load;
      logic next_pixel;
      logic frame_end;
   } lsefg_cmd_type;

   typedef struct packed {
      logic frame_due;
      logic need_div;
      logic div_last;
      logic pixel_last;
   } lsefg_status_type;

endpackage

`default_nettype wire

// ===== hdl/led_strip_effect_frame_gen.sv =====
// Top level of the LED strip effect frame generator.
// Instantiates lsefg_ctrl and lsefg_datapath; depends on lsefg_pkg.
`default_nettype none

// Each transfer on the req_ channel is a millisecond time stamp. When output is enabled and
// at least FRAME_INTERVAL_MS have passed since the last frame (unsigned, wrapping difference),
// the block emits one frame of STRIP_LEDS pixels on the rsp_ channel, in order of position,
// with rsp_frame_last set on the final pixel; otherwise the tick is taken and produces
// nothing. Pixels at or above the clamped LED count are black. In rainbow mode a lit pixel
// passes through the bit-serial divider, which forms position * 360 / count and gives one
// quotient bit a cycle, and then the hue step; static-mode and unlit pixels skip both. Each
// pixel then goes through the color, scale and norm steps. One frame is built at a time:
// req_stall stays high from the accepted tick until the last pixel is transferred. The csr_
// port may only be written while no frame is in progress.
module led_strip_effect_frame_gen #(
   parameter int STRIP_LEDS        = lsefg_pkg::STRIP_LEDS_DEF,
   parameter int FRAME_INTERVAL_MS = lsefg_pkg::FRAME_INTERVAL_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_wr_en,
   input  wire logic [lsefg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [lsefg_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [lsefg_pkg::TIME_W-1:0]     req_now_ms,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [lsefg_pkg::LED_W-1:0]           rsp_led_index,
   output logic [lsefg_pkg::CHAN_W-1:0]          rsp_red,
   output logic [lsefg_pkg::CHAN_W-1:0]          rsp_green,
   output logic [lsefg_pkg::CHAN_W-1:0]          rsp_blue,
   output logic                                  rsp_frame_last
);
   import lsefg_pkg::*;

   lsefg_cmd_type    cmd;
   lsefg_status_type status;

   lsefg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lsefg_datapath #(
      .STRIP_LEDS        (STRIP_LEDS),
      .FRAME_INTERVAL_MS (FRAME_INTERVAL_MS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_now_ms     (req_now_ms),
      .cmd            (cmd),
      .status         (status),
      .rsp_led_index  (rsp_led_index),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_frame_last (rsp_frame_last)
   );

   // No new tick is taken while a pixel waits for transfer.
   a_busy_while_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("tick accepted while a pixel is pending");

   // The last pixel of a frame sits at the last strip position.
   a_last_position: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_last) |-> (rsp_led_index == LED_W'(STRIP_LEDS - 1)))
      else $error("frame ended at the wrong position");

   // After the last pixel transfer the block is ready for the next tick.
   a_idle_after_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_frame_last) |=> !req_stall)
      else $error("not ready after the end of a frame");

   // A tick that is not due produces no frame.
   a_drop_not_due: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !status.frame_due) |=> (!req_stall && !rsp_valid))
      else $error("frame started for a tick that was not due");

endmodule

`default_nettype wire

// ===== hdl/lsefg_ctrl.sv =====
// Controller of the LED strip effect frame generator: sequences the steps of each pixel.
// Depends on lsefg_pkg for the command and status types.
`default_nettype none

module lsefg_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   input  wire lsefg_pkg::lsefg_status_type status,
   output lsefg_pkg::lsefg_cmd_type         cmd
);
   import lsefg_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PREP  = 3'd1;
   localparam logic [2:0] S_DIV   = 3'd2;
   localparam logic [2:0] S_HUE   = 3'd3;
   localparam logic [2:0] S_COLOR = 3'd4;
   localparam logic [2:0] S_SCALE = 3'd5;
   localparam logic [2:0] S_NORM  = 3'd6;
   localparam logic [2:0] S_OUT   = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            // A tick that is not due is taken and dropped here.
            if (req_valid && status.frame_due) begin
               cmd.frame_start = 1'b1;
               state_in        = S_PREP;
            end
         end
         S_PREP: begin
            if (status.need_div) begin
               cmd.div_init = 1'b1;
               state_in     = S_DIV;
            end else begin
               state_in = S_COLOR;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_HUE;
            end
         end
         S_HUE: begin
            cmd.hue_load = 1'b1;
            state_in     = S_COLOR;
         end
         S_COLOR: begin
            cmd.color_load = 1'b1;
            state_in       = S_SCALE;
         end
         S_SCALE: begin
            cmd.scale_load = 1'b1;
            state_in       = S_NORM;
         end
         S_NORM: begin
            cmd.norm_load = 1'b1;
            state_in      = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) begin
               if (status.pixel_last) begin
                  cmd.frame_end = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  cmd.next_pixel = 1'b1;
                  state_in       = S_PREP;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/lsefg_datapath.sv =====
// Datapath of the LED strip effect frame generator: configuration registers, frame timer,
// hue offset, bit-serial divider, hue wheel, brightness scaling and result registers.
// Depends on lsefg_pkg.
`default_nettype none

module lsefg_datapath #(
   parameter int STRIP_LEDS        = lsefg_pkg::STRIP_LEDS_DEF,
   parameter int FRAME_INTERVAL_MS = lsefg_pkg::FRAME_INTERVAL_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [lsefg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [lsefg_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire logic [lsefg_pkg::TIME_W-1:0]        req_now_ms,
   input  wire lsefg_pkg::lsefg_cmd_type            cmd,
   output lsefg_pkg::lsefg_status_type              status,
   output logic [lsefg_pkg::LED_W-1:0]              rsp_led_index,
   output logic [lsefg_pkg::CHAN_W-1:0]             rsp_red,
   output logic [lsefg_pkg::CHAN_W-1:0]             rsp_green,
   output logic [lsefg_pkg::CHAN_W-1:0]             rsp_blue,
   output logic                                     rsp_frame_last
);
   import lsefg_pkg::*;

   localparam int IDX_W  = (STRIP_LEDS > 1) ? $clog2(STRIP_LEDS) : 1;
   localparam int CNT_W  = $clog2(STRIP_LEDS + 1);
   localparam int CMP_W  = (CNT_W > CFG_CNT_W) ? CNT_W : CFG_CNT_W;
   localparam int NUM_W  = $clog2(STRIP_LEDS * int'(HUE_FULL) + 1);
   localparam int DCNT_W = $clog2(NUM_W);
   localparam int PROD_W = 2 * CHAN_W;

   // Configuration registers.
   logic               enable_ff;
   logic [CFG_CNT_W-1:0] count_cfg_ff;
   logic [CHAN_W-1:0]  bright_ff;
   logic [CHAN_W-1:0]  fix_red_ff;
   logic [CHAN_W-1:0]  fix_green_ff;
   logic [CHAN_W-1:0]  fix_blue_ff;
   logic               mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         count_cfg_ff <= ACTIVE_COUNT_RST;
         bright_ff    <= CHAN_MAX;
         fix_red_ff   <= '0;
         fix_green_ff <= '0;
         fix_blue_ff  <= '0;
         mode_ff      <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_OUTPUT_ENABLE: enable_ff    <= csr_wdata[0];
            REG_ACTIVE_COUNT:  count_cfg_ff <= csr_wdata[CFG_CNT_W-1:0];
            REG_BRIGHTNESS:    bright_ff    <= csr_wdata;
            REG_FIXED_RED:     fix_red_ff   <= csr_wdata;
            REG_FIXED_GREEN:   fix_green_ff <= csr_wdata;
            REG_FIXED_BLUE:    fix_blue_ff  <= csr_wdata;
            REG_EFFECT_MODE:   mode_ff      <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Clamped LED count.
   logic [CMP_W-1:0] cfg_cnt_ext;
   logic [CNT_W-1:0] count;

   assign cfg_cnt_ext = CMP_W'(count_cfg_ff);
   assign count = (cfg_cnt_ext == '0) ? CNT_W'(1) :
                  (cfg_cnt_ext > CMP_W'(STRIP_LEDS)) ? CNT_W'(STRIP_LEDS) :
                  CNT_W'(cfg_cnt_ext);

   // Frame timer, hue offset and pixel position.
   logic [TIME_W-1:0] last_time_ff;
   logic [TIME_W-1:0] elapsed;
   logic [HUE_W-1:0]  hue_off_ff;
   logic [HUE_W-1:0]  hue_off_in;
   logic [HUE_W:0]    hue_off_sum;
   logic [IDX_W-1:0]  idx_ff;
   logic [NUM_W-1:0]  pix_num_ff;
   logic              lit;

   assign elapsed     = req_now_ms - last_time_ff;
   assign hue_off_sum = {1'b0, hue_off_ff} + {1'b0, HUE_STEP};
   assign hue_off_in  = (hue_off_sum >= {1'b0, HUE_FULL}) ?
                        HUE_W'(hue_off_sum - {1'b0, HUE_FULL}) : HUE_W'(hue_off_sum);
   assign lit         = (CNT_W'(idx_ff) < count);

   always_ff @(posedge clock) begin
      if (reset) begin
         last_time_ff <= '0;
         hue_off_ff   <= '0;
         idx_ff       <= '0;
         pix_num_ff   <= '0;
      end else begin
         if (cmd.frame_start) begin
            last_time_ff <= req_now_ms;
            idx_ff       <= '0;
            pix_num_ff   <= '0;
         end
         if (cmd.next_pixel) begin
            idx_ff     <= idx_ff + IDX_W'(1);
            pix_num_ff <= pix_num_ff + NUM_W'(HUE_FULL);
         end
         if (cmd.frame_end && !mode_ff) begin
            hue_off_ff <= hue_off_in;
         end
      end
   end

   // Restoring divider, one quotient bit per cycle: position * 360 / count.
   logic [NUM_W-1:0]  div_num_ff;
   logic [NUM_W-1:0]  div_quo_ff;
   logic [CNT_W-1:0]  div_rem_ff;
   logic [DCNT_W-1:0] div_cnt_ff;
   logic [CNT_W:0]    div_trial;
   logic [CNT_W:0]    div_diff;
   logic              div_ge;

   assign div_trial = {div_rem_ff, div_num_ff[NUM_W-1]};
   assign div_diff  = div_trial - {1'b0, count};
   assign div_ge    = (div_trial >= {1'b0, count});

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         div_num_ff <= pix_num_ff;
         div_quo_ff <= '0;
         div_rem_ff <= '0;
         div_cnt_ff <= DCNT_W'(NUM_W - 1);
      end else if (cmd.div_step) begin
         div_num_ff <= div_num_ff << 1;
         div_quo_ff <= {div_quo_ff[NUM_W-2:0], div_ge};
         div_rem_ff <= div_ge ? div_diff[CNT_W-1:0] : div_trial[CNT_W-1:0];
         div_cnt_ff <= div_cnt_ff - DCNT_W'(1);
      end
   end

   // Hue of the pixel; the quotient stays below 360 for every lit pixel.
   logic [HUE_W-1:0] hue_ff;
   logic [HUE_W-1:0] hue_in;
   logic [HUE_W:0]   hue_sum;

   assign hue_sum = {1'b0, hue_off_ff} + {1'b0, HUE_W'(div_quo_ff)};
   assign hue_in  = (hue_sum >= {1'b0, HUE_FULL}) ?
                    HUE_W'(hue_sum - {1'b0, HUE_FULL}) : HUE_W'(hue_sum);

   always_ff @(posedge clock) begin
      if (cmd.hue_load) begin
         hue_ff <= hue_in;
      end
   end

   // Six-sector hue wheel. 255/60 is 17/4 exactly, so the ramp is rem*17 >> 2.
   logic [CHAN_W-1:0] color_red_ff, color_green_ff, color_blue_ff;
   logic [CHAN_W-1:0] color_red_in, color_green_in, color_blue_in;

   always_comb begin
      logic [HUE_W-1:0]  sec_base;
      logic [5:0]        sec_rem;
      logic [9:0]        frac_x17;
      logic [CHAN_W-1:0] frac;
      logic [CHAN_W-1:0] w_red, w_green, w_blue;

      if (hue_ff < HUE_SECTOR) begin
         sec_base = '0;
      end else if (hue_ff < HUE_W'(2 * HUE_SECTOR)) begin
         sec_base = HUE_SECTOR;
      end else if (hue_ff < HUE_W'(3 * HUE_SECTOR)) begin
         sec_base = HUE_W'(2 * HUE_SECTOR);
      end else if (hue_ff < HUE_W'(4 * HUE_SECTOR)) begin
         sec_base = HUE_W'(3 * HUE_SECTOR);
      end else if (hue_ff < HUE_W'(5 * HUE_SECTOR)) begin
         sec_base = HUE_W'(4 * HUE_SECTOR);
      end else begin
         sec_base = HUE_W'(5 * HUE_SECTOR);
      end
      sec_rem  = 6'(hue_ff - sec_base);
      frac_x17 = (10'(sec_rem) << 4) + 10'(sec_rem);
      frac     = frac_x17[9:2];

      if (sec_base == '0) begin
         w_red = CHAN_MAX;         w_green = frac;             w_blue = '0;
      end else if (sec_base == HUE_SECTOR) begin
         w_red = CHAN_MAX - frac;  w_green = CHAN_MAX;         w_blue = '0;
      end else if (sec_base == HUE_W'(2 * HUE_SECTOR)) begin
         w_red = '0;               w_green = CHAN_MAX;         w_blue = frac;
      end else if (sec_base == HUE_W'(3 * HUE_SECTOR)) begin
         w_red = '0;               w_green = CHAN_MAX - frac;  w_blue = CHAN_MAX;
      end else if (sec_base == HUE_W'(4 * HUE_SECTOR)) begin
         w_red = frac;             w_green = '0;               w_blue = CHAN_MAX;
      end else begin
         w_red = CHAN_MAX;         w_green = '0;               w_blue = CHAN_MAX - frac;
      end

      if (!lit) begin
         color_red_in = '0;            color_green_in = '0;
         color_blue_in = '0;
      end else if (mode_ff) begin
         color_red_in = fix_red_ff;    color_green_in = fix_green_ff;
         color_blue_in = fix_blue_ff;
      end else begin
         color_red_in = w_red;         color_green_in = w_green;
         color_blue_in = w_blue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.color_load) begin
         color_red_ff   <= color_red_in;
         color_green_ff <= color_green_in;
         color_blue_ff  <= color_blue_in;
      end
   end

   // Brightness products, then the exact divide by 255 in the next cycle.
   logic [PROD_W-1:0] prod_red_ff, prod_green_ff, prod_blue_ff;

   always_ff @(posedge clock) begin
      if (cmd.scale_load) begin
         prod_red_ff   <= PROD_W'(color_red_ff) * PROD_W'(bright_ff);
         prod_green_ff <= PROD_W'(color_green_ff) * PROD_W'(bright_ff);
         prod_blue_ff  <= PROD_W'(color_blue_ff) * PROD_W'(bright_ff);
      end
   end

   // (p + (p >> 8) + 1) >> 8 equals p / 255 for every p up to 255 * 255, the largest product.
   function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] p);
      logic [PROD_W:0] s;
      s = (PROD_W + 1)'(p) + (PROD_W + 1)'(p >> CHAN_W) + (PROD_W + 1)'(1);
      return s[PROD_W-1:CHAN_W];
   endfunction

   logic [LED_W-1:0]  rsp_led_index_ff;
   logic [CHAN_W-1:0] rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic              rsp_frame_last_ff;

   always_ff @(posedge clock) begin
      if (cmd.norm_load) begin
         rsp_led_index_ff  <= LED_W'(idx_ff);
         rsp_red_ff        <= div255(prod_red_ff);
         rsp_green_ff      <= div255(prod_green_ff);
         rsp_blue_ff       <= div255(prod_blue_ff);
         rsp_frame_last_ff <= status.pixel_last;
      end
   end

   assign rsp_led_index  = rsp_led_index_ff;
   assign rsp_red        = rsp_red_ff;
   assign rsp_green      = rsp_green_ff;
   assign rsp_blue       = rsp_blue_ff;
   assign rsp_frame_last = rsp_frame_last_ff;

   assign status.frame_due  = enable_ff && (elapsed >= TIME_W'(FRAME_INTERVAL_MS));
   assign status.need_div   = lit && !mode_ff;
   assign status.div_last   = (div_cnt_ff == '0);
   assign status.pixel_last = (idx_ff == IDX_W'(STRIP_LEDS - 1));

endmodule

`default_nettype wire

// ===== tb/tb_led_strip_effect_frame_gen.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for led_strip_effect_frame_gen: drives millisecond ticks and register
// writes, predicts every pixel of every frame and compares it with the rsp_ channel.
// Depends on lsefg_pkg and the led_strip_effect_frame_gen RTL.

module tb_led_strip_effect_frame_gen;
   import lsefg_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;
   localparam int SETTLE_CYCLES   = 8;
   localparam int DRAIN_CYCLES    = 40;
   localparam int HOLD_CYCLES     = 400;
   localparam int MAX_GAP         = 30;
   localparam int PHASES          = 8;
   localparam int TICKS_PER_PHASE = 25;

   typedef enum logic {ROW_WRITE, ROW_TICK} row_kind_type;

   typedef struct packed {
      row_kind_type             kind;
      logic [CSR_IDX_W-1:0]     index;
      logic [CSR_DATA_W-1:0]    data;
      logic [TIME_W-1:0]        now;
      logic                     typed;
      logic                     frame;
      logic [3*CHAN_W-1:0]      rgb;
   } dir_row_type;

   typedef struct packed {
      logic [LED_W-1:0]  led_index;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              frame_last;
   } pixel_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_wr_en  = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;
   logic                  req_valid  = 1'b0;
   logic [TIME_W-1:0]     req_now_ms = '0;
   logic                  rsp_stall  = 1'b0;
   wire logic             req_stall;
   wire logic             rsp_valid;
   wire logic [LED_W-1:0] rsp_led_index;
   wire logic [CHAN_W-1:0] rsp_red;
   wire logic [CHAN_W-1:0] rsp_green;
   wire logic [CHAN_W-1:0] rsp_blue;
   wire logic             rsp_frame_last;

   // Shadow copy of the registers and of the frame state.
   logic                 cfg_enable;
   logic [CFG_CNT_W-1:0] cfg_count;
   logic [CHAN_W-1:0]    cfg_bright;
   logic [CHAN_W-1:0]    cfg_red;
   logic [CHAN_W-1:0]    cfg_green;
   logic [CHAN_W-1:0]    cfg_blue;
   logic                 cfg_static;
   logic [TIME_W-1:0]    strip_last_ms;
   logic [HUE_W-1:0]     strip_hue;

   pixel_type pending_pixels[$];
   pixel_type got_px;
   pixel_type want_px;

   // Hand-written expectation of the tick being offered, for the directed rows.
   logic                typed_on    = 1'b0;
   logic                typed_frame = 1'b0;
   logic [3*CHAN_W-1:0] typed_rgb   = '0;

   int  send_idle_pct = 0;
   int  rsp_idle_pct  = 0;
   bit  hold_request  = 1'b0;
   int  hold_left     = 0;
   int  errors        = 0;
   int  ticks_taken   = 0;
   int  frames_built  = 0;
   int  pixels_checked = 0;

   dir_row_type       dir_tab[$];
   dir_row_type       row;
   logic [TIME_W-1:0] tick_now;
   int unsigned       sel;

   led_strip_effect_frame_gen uut (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_now_ms     (req_now_ms),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_led_index  (rsp_led_index),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_frame_last (rsp_frame_last)
   );

   always #5 clock = ~clock;

   initial begin
      #20_000_000;
      $display("tb_led_strip_effect_frame_gen: errors");
      $finish;
   end

   function automatic logic [CHAN_W-1:0] dim(input logic [CHAN_W-1:0] c);
      logic [2*CHAN_W-1:0] prod;
      prod = 16'(c) * 16'(cfg_bright);
      return CHAN_W'(prod / 16'(CHAN_MAX));
   endfunction

   // Six-sector integer hue wheel.
   function automatic logic [3*CHAN_W-1:0] hue_wheel(input int unsigned hue);
      int unsigned sector;
      int unsigned frac;
      logic [CHAN_W-1:0] up;
      logic [CHAN_W-1:0] down;
      sector = hue / HUE_SECTOR;
      frac = ((hue - sector * HUE_SECTOR) * CHAN_MAX) / HUE_SECTOR;
      up = CHAN_W'(frac);
      down = CHAN_MAX - up;
      case (sector)
         0: return {CHAN_MAX, up, 8'd0};
         1: return {down, CHAN_MAX, 8'd0};
         2: return {8'd0, CHAN_MAX, up};
         3: return {8'd0, down, CHAN_MAX};
         4: return {up, 8'd0, CHAN_MAX};
         default: return {CHAN_MAX, 8'd0, down};
      endcase
   endfunction

   // Works out the frame, if any, that an accepted tick causes.
   task automatic build_frame(input logic [TIME_W-1:0] now);
      logic [TIME_W-1:0]   elapsed;
      logic                due;
      int unsigned         lit;
      int unsigned         hue;
      int                  i;
      logic [3*CHAN_W-1:0] rgb;
      pixel_type           px;
      elapsed = now - strip_last_ms;
      due = cfg_enable && (elapsed >= FRAME_INTERVAL_DEF);
      if (typed_on && typed_frame != due) begin
         $display("%0t: tick %08h: expected frame %0b, predicted frame %0b",
                  $time, now, typed_frame, due);
         errors++;
      end
      if (due) begin
         strip_last_ms = now;
         if (cfg_count == 0)
            lit = 1;
         else if (cfg_count > STRIP_LEDS_DEF)
            lit = STRIP_LEDS_DEF;
         else
            lit = cfg_count;
         for (i = 0; i < STRIP_LEDS_DEF; i++) begin
            rgb = '0;
            if (i < lit) begin
               if (cfg_static) begin
                  rgb = {cfg_red, cfg_green, cfg_blue};
               end else begin
                  hue = (strip_hue + (i * HUE_FULL) / lit) % HUE_FULL;
                  rgb = hue_wheel(hue);
               end
               rgb = {dim(rgb[23:16]), dim(rgb[15:8]), dim(rgb[7:0])};
            end
            if (i == 0 && typed_on)
               rgb = typed_rgb;
            px.led_index  = i[LED_W-1:0];
            px.red        = rgb[23:16];
            px.green      = rgb[15:8];
            px.blue       = rgb[7:0];
            px.frame_last = (i == STRIP_LEDS_DEF - 1);
            if (!typed_on || typed_frame)
               pending_pixels.push_back(px);
         end
         if (!cfg_static)
            strip_hue = (strip_hue + HUE_STEP) % HUE_FULL;
         frames_built++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_enable    = 1'b0;
         cfg_count     = ACTIVE_COUNT_RST;
         cfg_bright    = CHAN_MAX;
         cfg_red       = '0;
         cfg_green     = '0;
         cfg_blue      = '0;
         cfg_static    = 1'b0;
         strip_last_ms = '0;
         strip_hue     = '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_OUTPUT_ENABLE: cfg_enable = csr_wdata[0];
               REG_ACTIVE_COUNT:  cfg_count  = csr_wdata[CFG_CNT_W-1:0];
               REG_BRIGHTNESS:    cfg_bright = csr_wdata;
               REG_FIXED_RED:     cfg_red    = csr_wdata;
               REG_FIXED_GREEN:   cfg_green  = csr_wdata;
               REG_FIXED_BLUE:    cfg_blue   = csr_wdata;
               REG_EFFECT_MODE:   cfg_static = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            ticks_taken++;
            build_frame(req_now_ms);
         end
         if (rsp_valid && !rsp_stall) begin
            got_px = {rsp_led_index, rsp_red, rsp_green, rsp_blue, rsp_frame_last};
            if (pending_pixels.size() == 0) begin
               $display("%0t: unexpected pixel idx %0d rgb %02h%02h%02h last %0b", $time,
                        got_px.led_index, got_px.red, got_px.green, got_px.blue,
                        got_px.frame_last);
               errors++;
            end else begin
               want_px = pending_pixels.pop_front();
               pixels_checked++;
               if (got_px != want_px) begin
                  $display("%0t: expected %0d %02h%02h%02h %0b, got %0d %02h%02h%02h %0b",
                           $time, want_px.led_index, want_px.red, want_px.green,
                           want_px.blue, want_px.frame_last, got_px.led_index, got_px.red,
                           got_px.green, got_px.blue, got_px.frame_last);
                  errors++;
               end
            end
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off counted here when asked for.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
      end
   end

   task automatic send_tick(input logic [TIME_W-1:0] now, input logic typed,
                            input logic frame, input logic [3*CHAN_W-1:0] rgb);
      int gap;
      gap = 0;
      @(negedge clock);
      while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         gap++;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_now_ms  <= now;
      typed_on    = typed;
      typed_frame = frame;
      typed_rgb   = rgb;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   // Stops offering ticks until every pixel is in and the block has gone idle.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic configure_phase(input int p);
      logic [CSR_DATA_W-1:0] cnt;
      logic [CSR_DATA_W-1:0] lvl;
      logic [CSR_DATA_W-1:0] mode;
      logic [CSR_DATA_W-1:0] en;
      en = 8'($urandom_range(0, 255));
      en[0] = (p < 2) || ($urandom_range(0, 7) != 0);
      cnt = (p == 0) ? 8'd32 : (p == 1) ? 8'd1 : 8'($urandom_range(0, 255));
      lvl = (p == 0) ? CHAN_MAX : (p == 2) ? 8'd1 : 8'($urandom_range(0, 255));
      mode = 8'($urandom_range(0, 255));
      mode[0] = (p >= 2) && ($urandom_range(0, 2) == 0);
      csr_write(REG_OUTPUT_ENABLE, en);
      csr_write(REG_ACTIVE_COUNT, cnt);
      csr_write(REG_BRIGHTNESS, lvl);
      csr_write(REG_FIXED_RED, 8'($urandom_range(0, 255)));
      csr_write(REG_FIXED_GREEN, 8'($urandom_range(0, 255)));
      csr_write(REG_FIXED_BLUE, 8'($urandom_range(0, 255)));
      csr_write(REG_EFFECT_MODE, mode);
   endtask

   function automatic dir_row_type row_write(input logic [CSR_IDX_W-1:0] idx,
                                             input logic [CSR_DATA_W-1:0] data);
      dir_row_type r;
      r = '0;
      r.kind  = ROW_WRITE;
      r.index = idx;
      r.data  = data;
      return r;
   endfunction

   function automatic dir_row_type row_tick(input logic [TIME_W-1:0] now, input logic typed,
                                            input logic frame, input logic [3*CHAN_W-1:0] rgb);
      dir_row_type r;
      r = '0;
      r.kind  = ROW_TICK;
      r.now   = now;
      r.typed = typed;
      r.frame = frame;
      r.rgb   = rgb;
      return r;
   endfunction

   initial begin
      // Disabled after reset, then the interval boundary from a last frame at time zero.
      dir_tab.push_back(row_tick(32'd100, 1'b1, 1'b0, 24'h0));
      dir_tab.push_back(row_write(REG_OUTPUT_ENABLE, 8'h01));
      dir_tab.push_back(row_tick(32'd30, 1'b1, 1'b0, 24'h0));
      dir_tab.push_back(row_tick(32'd49, 1'b1, 1'b0, 24'h0));
      dir_tab.push_back(row_tick(32'd50, 1'b1, 1'b1, 24'hFF0000));
      dir_tab.push_back(row_tick(32'd99, 1'b1, 1'b0, 24'h0));
      dir_tab.push_back(row_tick(32'd100, 1'b0, 1'b0, 24'h0));
      // Count of zero acts as one; a count above the strip length is clamped.
      dir_tab.push_back(row_write(REG_ACTIVE_COUNT, 8'h00));
      dir_tab.push_back(row_tick(32'd200, 1'b0, 1'b0, 24'h0));
      dir_tab.push_back(row_write(REG_ACTIVE_COUNT, 8'hFF));
      dir_tab.push_back(row_tick(32'd300, 1'b0, 1'b0, 24'h0));
      dir_tab.push_back(row_write(REG_ACTIVE_COUNT, 8'd33));
      dir_tab.push_back(row_tick(32'd360, 1'b0, 1'b0, 24'h0));
      dir_tab.push_back(row_write(REG_BRIGHTNESS, 8'h00));
      dir_tab.push_back(row_tick(32'd420, 1'b1, 1'b1, 24'h000000));
      // Static color, first at half brightness and then at full brightness.
      dir_tab.push_back(row_write(REG_BRIGHTNESS, 8'd128));
      dir_tab.push_back(row_write(REG_EFFECT_MODE, 8'h01));
      dir_tab.push_back(row_write(REG_FIXED_RED, 8'hFF));
      dir_tab.push_back(row_write(REG_FIXED_GREEN, 8'h80));
      dir_tab.push_back(row_write(REG_FIXED_BLUE, 8'h01));
      dir_tab.push_back(row_tick(32'd500, 1'b0, 1'b0, 24'h0));
      dir_tab.push_back(row_write(REG_BRIGHTNESS, 8'hFF));
      dir_tab.push_back(row_tick(32'd600, 1'b1, 1'b1, 24'hFF8001));
      // Time wraps past the top of the counter.
      dir_tab.push_back(row_tick(32'hFFFF_FFFF, 1'b0, 1'b0, 24'h0));
      dir_tab.push_back(row_tick(32'h0000_0020, 1'b1, 1'b0, 24'h0));
      dir_tab.push_back(row_tick(32'h0000_0031, 1'b0, 1'b0, 24'h0));
      // Writes beyond the register list are dropped and wide values are masked.
      dir_tab.push_back(row_write(REG_UNUSED, 8'hFF));
      dir_tab.push_back(row_write(REG_EFFECT_MODE, 8'hFE));
      dir_tab.push_back(row_write(REG_ACTIVE_COUNT, 8'hC1));
      dir_tab.push_back(row_tick(32'h0000_0100, 1'b0, 1'b0, 24'h0));
      dir_tab.push_back(row_write(REG_OUTPUT_ENABLE, 8'hFE));
      dir_tab.push_back(row_tick(32'h0000_0200, 1'b1, 1'b0, 24'h0));
      dir_tab.push_back(row_write(REG_OUTPUT_ENABLE, 8'h01));

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      for (int n = 0; n < dir_tab.size(); n++) begin
         row = dir_tab[n];
         if (row.kind == ROW_WRITE) begin
            settle();
            csr_write(row.index, row.data);
         end else begin
            send_tick(row.now, row.typed, row.frame, row.rgb);
         end
      end

      tick_now = 32'h0000_0200;
      for (int p = 0; p < PHASES; p++) begin
         settle();
         if (p < 3) begin
            send_idle_pct = 23;
            rsp_idle_pct  = 62;
         end else if (p < 6) begin
            send_idle_pct = 62;
            rsp_idle_pct  = 23;
         end else begin
            send_idle_pct = 0;
            rsp_idle_pct  = 0;
         end
         configure_phase(p);
         for (int k = 0; k < TICKS_PER_PHASE; k++) begin
            // The long receiver hold-off backs the block up while ticks keep coming.
            if (p == 1 && k == 3)
               hold_request = 1'b1;
            if (p == 4 && k == 12)
               settle();
            sel = $urandom_range(0, 99);
            if (sel < 65)
               tick_now = tick_now + $urandom_range(50, 120);
            else if (sel < 85)
               tick_now = tick_now + $urandom_range(0, 49);
            else if (sel < 92)
               tick_now = $urandom;
            else if (sel < 96)
               tick_now = 32'hFFFF_FFFF - $urandom_range(0, 100);
            else
               tick_now = tick_now + FRAME_INTERVAL_DEF - $urandom_range(0, 1);
            send_tick(tick_now, 1'b0, 1'b0, 24'h0);
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Ran the directed table and %0d random register settings: %0d ticks accepted.",
               PHASES, ticks_taken);
      $display("%0d frames predicted, %0d pixels compared, %0d mismatches.",
               frames_built, pixels_checked, errors);
      if (errors == 0)
         $display("tb_led_strip_effect_frame_gen: clean");
      else
         $display("tb_led_strip_effect_frame_gen: errors");
      $finish;
   end

endmodule

// ===== led_strip_effect_frame_gen.f =====
hdl/lsefg_pkg.sv
hdl/lsefg_ctrl.sv
hdl/lsefg_datapath.sv
hdl/led_strip_effect_frame_gen.sv
tb/tb_led_strip_effect_frame_gen.sv
